// ----- hdl/complex_arithmetic_unit_core_macros.svh -----
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`ifndef SYNTH
`define CAU_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAU_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CAU_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define CAU_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- hdl/cau_pkg.sv -----
package cau_pkg;
  localparam int unsigned DataWidth = 16;
  localparam int unsigned FracBits  = 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;
endpackage

// ----- hdl/cau_div.sv -----
module cau_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 33
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o
);
  // pipelined restoring divider: one quotient bit per stage, unsigned operands
  logic [NumW-1:0] quo_q [NumW+1];
  logic [DenW-1:0] rem_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];

  assign quo_q[0] = num_i;
  assign rem_q[0] = '0;
  assign den_q[0] = den_i;

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic [NumW-1:0] quo_d;
    logic [DenW-1:0] rem_d;
    logic [NumW-1:0] quo_r_q;
    logic [DenW-1:0] rem_r_q;
    logic [DenW-1:0] den_r_q;
    always_comb begin
      trial = {rem_q[s], quo_q[s][NumW-1]};
      diff  = trial - {1'b0, den_q[s]};
    end
    always_comb begin
      if (!diff[DenW]) begin
        rem_d = diff[DenW-1:0];
        quo_d = {quo_q[s][NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[s][NumW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_r_q <= quo_d;
        rem_r_q <= rem_d;
        den_r_q <= den_q[s];
      end
    end
    assign quo_q[s+1] = quo_r_q;
    assign rem_q[s+1] = rem_r_q;
    assign den_q[s+1] = den_r_q;
  end

  assign quo_o = quo_q[NumW];
endmodule

// ----- hdl/complex_arithmetic_unit_core.sv -----
// Complex ALU on signed fixed point operands (DataWidth bits, FracBits fraction): add,
// subtract, multiply and divide, saturating results and flagging divide by zero. Fully
// pipelined: one item per cycle while the sink does not stall it; every opcode takes the
// same path through the bit-per-stage divider, so that order is kept. Backpressure stalls
// the whole pipeline; an output register parts it from the sink.
`include "complex_arithmetic_unit_core_macros.svh"
module complex_arithmetic_unit_core #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DataWidth,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // a_real, a_imag, b_real, b_imag
  input  logic [4*DATA_WIDTH-1:0] s_axis_tdata_i,
  // req_type
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // res_real, res_imag
  output logic [2*DATA_WIDTH-1:0] m_axis_tdata_o,
  // div_by_zero, saturated
  output logic [1:0]            m_axis_tuser_o
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2*W + 1;          // product sum width
  localparam int unsigned NW = 2*W + FRAC_BITS + 1; // divider numerator magnitude
  localparam int unsigned DW = 2*W + 1;          // |b|^2 width
  localparam int unsigned DL = NW;               // divider stage count
  localparam int unsigned RW = NW + 1;           // result width before clamp

  logic adv;
  logic out_v_q;
  assign adv = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // stage 1: register operands
  logic v1_q;
  cau_pkg::op_e op1_q;
  logic signed [W-1:0] ar1_q, ai1_q, br1_q, bi1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= s_axis_tvalid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q <= cau_pkg::op_e'(s_axis_tuser_i);
      ar1_q <= s_axis_tdata_i[W-1:0];
      ai1_q <= s_axis_tdata_i[2*W-1:W];
      br1_q <= s_axis_tdata_i[3*W-1:2*W];
      bi1_q <= s_axis_tdata_i[4*W-1:3*W];
    end
  end

  // stage 2: add/sub sums, the four cross products and the squares of b
  logic v2_q;
  cau_pkg::op_e op2_q;
  logic signed [W:0] sr2_q, si2_q;
  logic signed [2*W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, sq_r_q, sq_i_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q  <= op1_q;
      if (op1_q == cau_pkg::OP_SUB) begin
        sr2_q <= {ar1_q[W-1], ar1_q} - {br1_q[W-1], br1_q};
        si2_q <= {ai1_q[W-1], ai1_q} - {bi1_q[W-1], bi1_q};
      end else begin
        sr2_q <= {ar1_q[W-1], ar1_q} + {br1_q[W-1], br1_q};
        si2_q <= {ai1_q[W-1], ai1_q} + {bi1_q[W-1], bi1_q};
      end
      p_rr_q <= ar1_q * br1_q;
      p_ii_q <= ai1_q * bi1_q;
      p_ri_q <= ar1_q * bi1_q;
      p_ir_q <= ai1_q * br1_q;
      sq_r_q <= br1_q * br1_q;
      sq_i_q <= bi1_q * bi1_q;
    end
  end

  // stage 3: sums, direct results for add/sub/mul, divider operands
  logic signed [PW-1:0] mre, mim, nre, nim;
  logic [DW-1:0] den;
  always_comb begin
    mre = PW'(p_rr_q) - PW'(p_ii_q);
    mim = PW'(p_ri_q) + PW'(p_ir_q);
    nre = PW'(p_rr_q) + PW'(p_ii_q);
    nim = PW'(p_ir_q) - PW'(p_ri_q);
    den = DW'(unsigned'(sq_r_q)) + DW'(unsigned'(sq_i_q));
  end

  logic v3_q;
  cau_pkg::op_e op3_q;
  logic signed [RW-1:0] dr3_q, di3_q;
  logic [NW-1:0] nr_mag3_q, ni_mag3_q;
  logic nr_neg3_q, ni_neg3_q, dz3_q;
  logic [DW-1:0] den3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op3_q <= op2_q;
      if (op2_q == cau_pkg::OP_MUL) begin
        dr3_q <= RW'(mre >>> FRAC_BITS);
        di3_q <= RW'(mim >>> FRAC_BITS);
      end else begin
        dr3_q <= RW'(sr2_q);
        di3_q <= RW'(si2_q);
      end
      nr_neg3_q <= nre[PW-1];
      ni_neg3_q <= nim[PW-1];
      nr_mag3_q <= NW'(nre[PW-1] ? -nre : nre) << FRAC_BITS;
      ni_mag3_q <= NW'(nim[PW-1] ? -nim : nim) << FRAC_BITS;
      den3_q <= den;
      dz3_q  <= den == '0;
    end
  end

  // divider, with side data delayed alongside
  logic [NW-1:0] qr, qi;
  cau_div #(.NumW(NW), .DenW(DW)) u_div_re (
    .clk_i(clk_i), .en_i(adv), .num_i(nr_mag3_q), .den_i(den3_q), .quo_o(qr));
  cau_div #(.NumW(NW), .DenW(DW)) u_div_im (
    .clk_i(clk_i), .en_i(adv), .num_i(ni_mag3_q), .den_i(den3_q), .quo_o(qi));

  typedef struct packed {
    logic              v;
    logic              div;
    logic              dz;
    logic              nr_neg;
    logic              ni_neg;
    logic [RW-1:0]     dr;
    logic [RW-1:0]     di;
  } side_t;

  side_t side_q [DL+1];
  assign side_q[0] = '{v: v3_q, div: op3_q == cau_pkg::OP_DIV, dz: dz3_q,
                       nr_neg: nr_neg3_q, ni_neg: ni_neg3_q, dr: dr3_q, di: di3_q};
  for (genvar s = 0; s < DL; s++) begin : g_side
    side_t sd_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sd_q <= '0;
      else if (adv) sd_q <= side_q[s];
    end
    assign side_q[s+1] = sd_q;
  end

  // final: select, clamp, register output
  side_t fin;
  logic signed [RW-1:0] rr, ri;
  logic signed [W-1:0] cr, ci;
  logic sr, si;
  localparam logic signed [RW-1:0] Hi = RW'((64'd1 << (W-1)) - 64'd1);
  localparam logic signed [RW-1:0] Lo = -Hi - RW'(1);
  always_comb begin
    fin = side_q[DL];
    if (fin.div) begin
      rr = fin.nr_neg ? -signed'({1'b0, qr}) : signed'({1'b0, qr});
      ri = fin.ni_neg ? -signed'({1'b0, qi}) : signed'({1'b0, qi});
    end else begin
      rr = fin.dr;
      ri = fin.di;
    end
    sr = 1'b0;
    si = 1'b0;
    if (rr > Hi) begin cr = Hi[W-1:0]; sr = 1'b1; end
    else if (rr < Lo) begin cr = Lo[W-1:0]; sr = 1'b1; end
    else cr = rr[W-1:0];
    if (ri > Hi) begin ci = Hi[W-1:0]; si = 1'b1; end
    else if (ri < Lo) begin ci = Lo[W-1:0]; si = 1'b1; end
    else ci = ri[W-1:0];
    if (fin.div && fin.dz) begin
      cr = '0;
      ci = '0;
      sr = 1'b0;
      si = 1'b0;
    end
  end

  logic [2*W-1:0] out_d_q;
  logic [1:0] out_u_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= fin.v;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_d_q <= {ci, cr};
      out_u_q <= {sr | si, fin.div & fin.dz};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_d_q;
  assign m_axis_tuser_o  = out_u_q;

  `CAU_ASSERT_NEVER(a_dz_no_sat, clk_i, rst_ni,
                    m_axis_tvalid_o && m_axis_tuser_o[0] && m_axis_tuser_o[1],
                    "divide by zero with saturation")
  `CAU_ASSERT_NEVER(a_dz_zero, clk_i, rst_ni,
                    m_axis_tvalid_o && m_axis_tuser_o[0] && (m_axis_tdata_o != '0),
                    "divide by zero result not zero")
  `CAU_ASSERT_IMPL(a_stall_hold, clk_i, rst_ni,
                   (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o),
                   "output changed during stall")
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Dw = cau_pkg::DataWidth;
  localparam int unsigned Fb = cau_pkg::FracBits;
  localparam int unsigned Latency = 4 + 2 * Dw + Fb + 1;
  localparam int unsigned NumRandom = 1500;
  localparam longint unsigned CycleLimit = 400000;
  localparam logic [Dw-1:0] MaxVal = {1'b0, {(Dw-1){1'b1}}};
  localparam logic [Dw-1:0] MinVal = {1'b1, {(Dw-1){1'b0}}};

  typedef struct packed {
    cau_pkg::op_e op;
    logic [Dw-1:0] ar;
    logic [Dw-1:0] ai;
    logic [Dw-1:0] br;
    logic [Dw-1:0] bi;
  } operands_t;

  typedef struct packed {
    logic [Dw-1:0] re;
    logic [Dw-1:0] im;
    logic dz;
    logic sat;
  } cplx_result_t;

  typedef struct {
    operands_t opnd;
    logic known;
    cplx_result_t res;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [4*Dw-1:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [2*Dw-1:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;

  cplx_result_t expected_q[$];
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 61;

  always #5 clk_i = ~clk_i;

  complex_arithmetic_unit_core dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  function automatic longint clamp_component(longint v, ref logic sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (Dw - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic cplx_result_t complex_alu(operands_t x);
    cplx_result_t r;
    longint ar, ai, br, bi, re, im, den;
    logic sat;
    ar = longint'($signed(x.ar));
    ai = longint'($signed(x.ai));
    br = longint'($signed(x.br));
    bi = longint'($signed(x.bi));
    re = 0;
    im = 0;
    sat = 1'b0;
    r.dz = 1'b0;
    case (x.op)
      cau_pkg::OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        // arithmetic shift floors toward minus infinity
        re = (ar * br - ai * bi) >>> Fb;
        im = (ar * bi + ai * br) >>> Fb;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          re = ((ar * br + ai * bi) * (longint'(1) <<< Fb)) / den;
          im = ((ai * br - ar * bi) * (longint'(1) <<< Fb)) / den;
        end
      end
    endcase
    if (!r.dz) begin
      re = clamp_component(re, sat);
      im = clamp_component(im, sat);
    end
    r.re = re[Dw-1:0];
    r.im = im[Dw-1:0];
    r.sat = sat;
    return r;
  endfunction

  function automatic logic [Dw-1:0] rand_component();
    case ($urandom_range(0, 9))
      0: return MaxVal;
      1: return MinVal;
      2: return '0;
      3, 4: return Dw'($signed($urandom_range(0, 1023)) - 512);
      default: return Dw'($urandom);
    endcase
  endfunction

  function automatic operands_t rand_operands();
    operands_t x;
    x.op = cau_pkg::op_e'($urandom_range(0, 3));
    x.ar = rand_component();
    x.ai = rand_component();
    x.br = rand_component();
    x.bi = rand_component();
    if (x.op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
      x.br = '0;
      x.bi = '0;
    end
    return x;
  endfunction

  task automatic send_item(operands_t x, logic known, cplx_result_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= x.op;
    s_axis_tdata_i <= {x.bi, x.br, x.ai, x.ar};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_q.push_back(known ? res : complex_alu(x));
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // sink side: random stall, check each accepted item against the oldest expectation
  always @(posedge clk_i) begin
    cplx_result_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.re  = m_axis_tdata_o[Dw-1:0];
      got.im  = m_axis_tdata_o[2*Dw-1:Dw];
      got.dz  = m_axis_tuser_o[0];
      got.sat = m_axis_tuser_o[1];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch re %h/%h im %h/%h dz %b/%b sat %b/%b (exp/got)",
                     want.re, got.re, want.im, got.im, want.dz, got.dz, want.sat, got.sat);
          end
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t row;
    cplx_result_t none;
    none = '0;
    // directed rows; known results only where obvious
    rows.push_back('{'{cau_pkg::OP_ADD, MaxVal, MinVal, MaxVal, MinVal}, 1'b1,
                     '{MaxVal, MinVal, 1'b0, 1'b1}});
    rows.push_back('{'{cau_pkg::OP_SUB, MinVal, MaxVal, 16'h0001, MinVal}, 1'b1,
                     '{MinVal, MaxVal, 1'b0, 1'b1}});
    rows.push_back('{'{cau_pkg::OP_ADD, 16'h0100, 16'h0200, 16'h0300, 16'hff00}, 1'b1,
                     '{16'h0400, 16'h0100, 1'b0, 1'b0}});
    rows.push_back('{'{cau_pkg::OP_SUB, 16'h0000, 16'h0000, MinVal, MaxVal}, 1'b1,
                     '{MaxVal, 16'h8001, 1'b0, 1'b1}});
    rows.push_back('{'{cau_pkg::OP_DIV, MaxVal, MinVal, 16'h0000, 16'h0000}, 1'b1,
                     '{16'h0000, 16'h0000, 1'b1, 1'b0}});
    rows.push_back('{'{cau_pkg::OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
                     '{16'h0000, 16'h0000, 1'b1, 1'b0}});
    rows.push_back('{'{cau_pkg::OP_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000}, 1'b1,
                     '{16'h0100, 16'h0000, 1'b0, 1'b0}});
    rows.push_back('{'{cau_pkg::OP_MUL, MinVal, MinVal, MinVal, MinVal}, 1'b0, none});
    rows.push_back('{'{cau_pkg::OP_MUL, MaxVal, MaxVal, MaxVal, MinVal}, 1'b0, none});
    rows.push_back('{'{cau_pkg::OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000}, 1'b0, none});
    rows.push_back('{'{cau_pkg::OP_MUL, 16'h0180, 16'hfe80, 16'h0040, 16'hff00}, 1'b0, none});
    rows.push_back('{'{cau_pkg::OP_DIV, MaxVal, MaxVal, 16'h0001, 16'h0000}, 1'b0, none});
    rows.push_back('{'{cau_pkg::OP_DIV, MinVal, MinVal, 16'h0000, 16'hffff}, 1'b0, none});
    rows.push_back('{'{cau_pkg::OP_DIV, 16'h0100, 16'h0000, MinVal, MinVal}, 1'b0, none});
    rows.push_back('{'{cau_pkg::OP_DIV, 16'hff00, 16'h0100, 16'h0300, 16'hfd00}, 1'b0, none});
    rows.push_back('{'{cau_pkg::OP_DIV, MaxVal, MinVal, MaxVal, MaxVal}, 1'b0, none});
    rows.push_back('{'{cau_pkg::OP_DIV, 16'h0001, 16'hffff, 16'h0000, 16'h0001}, 1'b0, none});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.opnd, row.known, row.res);
    end
    // hold the source until the pipeline has emptied once
    wait_drained();

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 19;
      end else if (n == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_item(rand_operands(), 1'b0, none);
    end
    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
